### design/adc_result_to_volts_or_temperature_defines.svh
// Assertion macros shared by the converter result scaling block.
`ifndef ADC_RESULT_TO_VOLTS_OR_TEMPERATURE_DEFINES_SVH
`define ADC_RESULT_TO_VOLTS_OR_TEMPERATURE_DEFINES_SVH
// same-cycle implication, checked out of reset
`define ADCRV_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, checked out of reset
`define ADCRV_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

### design/adcrv_pkg.sv
// Types and constants of the converter result scaling block.
package adcrv_pkg;

    localparam logic [4:0] CH_TEMP     = 5'd24;
    localparam logic [4:0] CH_BANDGAP  = 5'd25;
    localparam logic [4:0] CH_SUPPLY_A = 5'd26;
    localparam logic [4:0] CH_SUPPLY_B = 5'd27;

    localparam logic [2:0] CFG_ROOM_TEMP  = 3'd0;
    localparam logic [2:0] CFG_HOT_TEMP   = 3'd1;
    localparam logic [2:0] CFG_ROOM_CODE  = 3'd2;
    localparam logic [2:0] CFG_HOT_CODE   = 3'd3;
    localparam logic [2:0] CFG_ROOM_DRIFT = 3'd4;
    localparam logic [2:0] CFG_HOT_DRIFT  = 3'd5;
    localparam logic [2:0] CFG_IREF       = 3'd6;
    localparam logic [2:0] CFG_PIN_FS     = 3'd7;

    localparam int DIVIDEND_W = 80;
    localparam int DIVISOR_W  = 50;
    localparam int QUOT_W     = 33;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef struct packed {
        logic [4:0]  channel;
        logic [11:0] raw_code;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] value;
        logic               is_temperature;
        logic               calib_error;
    } t_out_item;

    typedef struct packed {
        logic [11:0]       room_temp_tenths;
        logic [11:0]       hot_temp_tenths;
        logic [11:0]       room_code;
        logic [11:0]       hot_code;
        logic signed [7:0] room_ref_drift;
        logic signed [7:0] hot_ref_drift;
        logic [16:0]       internal_ref_volts;
        logic [18:0]       pin_full_scale_volts;
    } t_cfg;

    // one rounded division: value = round(65536 * num / den)
    typedef struct packed {
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
        logic                  neg;
        logic                  is_temp;
        logic                  err;
    } t_job;

    typedef struct packed {
        logic full;
        logic nonempty;
    } t_q_stat;

endpackage

### design/adc_result_to_volts_or_temperature.sv
// Top level: converter result to Q16.16 volts or degrees C, with config registers.
//
// Item channel: pulse start with a channel number and a raw converter code in
// i_item; the item is taken at a rising edge where start is high and busy is
// low. A new item may be given every cycle.
// Result channel: o_res_valid is high for one cycle with o_result (value,
// is_temperature, calib_error). The receiver cannot stall; results leave in
// the order items came in, one per item.
// Pipeline: the front end spends ten stages (products of the two-point
// calibration, at most one multiplier deep per stage), the job queue one, and
// the divider 35: entry, 33 quotient bits one per stage, and saturation.
// Throughput: one item per cycle while busy is low.
// Config: write i_cfg_index / i_cfg_data with i_cfg_valid; o_cfg_ready is
// always high. Write only while no item is in flight.
// Reset (synchronous, active low) empties the pipeline and queue and restores
// the register defaults: reference and pin full scale at 1.0 V, rest zero.
`include "adc_result_to_volts_or_temperature_defines.svh"

module adc_result_to_volts_or_temperature #(
    parameter int CODE_BITS = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  adcrv_pkg::t_in_item  i_item,
    output logic                 o_res_valid,
    output adcrv_pkg::t_out_item o_result,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [18:0]          i_cfg_data
);

    adcrv_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg                      <= '0;
            r_cfg.internal_ref_volts   <= 17'd65536;
            r_cfg.pin_full_scale_volts <= 19'd65536;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                adcrv_pkg::CFG_ROOM_TEMP:  r_cfg.room_temp_tenths     <= i_cfg_data[11:0];
                adcrv_pkg::CFG_HOT_TEMP:   r_cfg.hot_temp_tenths      <= i_cfg_data[11:0];
                adcrv_pkg::CFG_ROOM_CODE:  r_cfg.room_code            <= i_cfg_data[11:0];
                adcrv_pkg::CFG_HOT_CODE:   r_cfg.hot_code             <= i_cfg_data[11:0];
                adcrv_pkg::CFG_ROOM_DRIFT: r_cfg.room_ref_drift       <= i_cfg_data[7:0];
                adcrv_pkg::CFG_HOT_DRIFT:  r_cfg.hot_ref_drift        <= i_cfg_data[7:0];
                adcrv_pkg::CFG_IREF:       r_cfg.internal_ref_volts   <= i_cfg_data[16:0];
                adcrv_pkg::CFG_PIN_FS:     r_cfg.pin_full_scale_volts <= i_cfg_data[18:0];
            endcase
        end
    end

    logic                w_take;
    logic                w_fjob_v, w_qjob_v;
    adcrv_pkg::t_job     w_fjob, w_qjob;
    adcrv_pkg::t_q_stat  w_qstat;

    // the divider drains the queue every cycle, so it only fills on a fault
    assign busy   = w_qstat.full;
    assign w_take = start && !busy;

    adcrv_front #(
        .CODE_BITS (CODE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (w_take),
        .i_item      (i_item),
        .i_cfg       (r_cfg),
        .o_job_valid (w_fjob_v),
        .o_job       (w_fjob)
    );

    adcrv_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_fjob_v),
        .i_job       (w_fjob),
        .o_job_valid (w_qjob_v),
        .o_job       (w_qjob),
        .o_stat      (w_qstat)
    );

    adcrv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_qjob_v),
        .i_job       (w_qjob),
        .o_res_valid (o_res_valid),
        .o_result    (o_result)
    );

    // checks
    `ADCRV_ASSERT_IMP(a_err_temp_zero, o_res_valid && o_result.calib_error, o_result.is_temperature && (o_result.value == 32'sd0), "calibration error on non-temperature or nonzero result")
    `ADCRV_ASSERT_IMP(a_volts_nonneg, o_res_valid && !o_result.is_temperature, !o_result.value[31], "negative voltage result")
    `ADCRV_ASSERT_NXT(a_queue_drains, w_qstat.nonempty, !w_qstat.full, "job queue backed up")

endmodule

### design/adcrv_front.sv
// Front end: accepts items, classifies the channel and forms the division job.
module adcrv_front #(
    parameter int CODE_BITS = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  adcrv_pkg::t_in_item i_item,
    input  adcrv_pkg::t_cfg  i_cfg,
    output logic             o_job_valid,
    output adcrv_pkg::t_job  o_job
);

    localparam logic [49:0] FS_VAL   = 50'((1 << CODE_BITS) - 1);
    localparam logic [49:0] VOLT_DEN = FS_VAL << 16;

    // valid chain, stages A through J
    logic [9:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[8:0], i_take};
        end
    end

    // stage A: capture
    logic [4:0]  r_a_ch;
    logic [11:0] r_a_raw;

    always_ff @(posedge i_clk) begin
        r_a_ch  <= i_item.channel;
        r_a_raw <= i_item.raw_code;
    end

    // stage B: reference terms, first products, channel class
    logic [11:0]       w_aref, w_bref;
    logic signed [8:0] w_dba;
    logic [22:0]       w_rv, w_hv;
    logic [21:0]       w_xk;
    logic signed [12:0] w_dt;
    logic [18:0]       w_s;
    logic [30:0]       w_prod;
    logic              w_temp;

    assign w_aref = 12'd1000 - {{4{i_cfg.room_ref_drift[7]}}, i_cfg.room_ref_drift};
    assign w_bref = 12'd1000 - {{4{i_cfg.hot_ref_drift[7]}}, i_cfg.hot_ref_drift};
    assign w_dba  = $signed({i_cfg.room_ref_drift[7], i_cfg.room_ref_drift})
                  - $signed({i_cfg.hot_ref_drift[7], i_cfg.hot_ref_drift});
    assign w_rv   = 23'(w_aref[10:0]) * 23'(i_cfg.room_code);
    assign w_hv   = 23'(w_bref[10:0]) * 23'(i_cfg.hot_code);
    assign w_xk   = 22'(r_a_raw) * 22'd1000;
    assign w_dt   = $signed({1'b0, i_cfg.hot_temp_tenths})
                  - $signed({1'b0, i_cfg.room_temp_tenths});
    assign w_temp = (r_a_ch == adcrv_pkg::CH_TEMP);

    always_comb begin
        priority if (r_a_ch == adcrv_pkg::CH_BANDGAP) begin
            w_s = {1'b0, i_cfg.internal_ref_volts, 1'b0};
        end else if (r_a_ch == adcrv_pkg::CH_SUPPLY_A || r_a_ch == adcrv_pkg::CH_SUPPLY_B) begin
            w_s = {i_cfg.internal_ref_volts, 2'b00};
        end else begin
            w_s = i_cfg.pin_full_scale_volts;
        end
    end
    assign w_prod = 31'(w_s) * 31'(r_a_raw);

    logic               r_b_temp;
    logic [11:0]        r_b_raw;
    logic [10:0]        r_b_a;
    logic signed [8:0]  r_b_dba;
    logic [22:0]        r_b_rv, r_b_hv;
    logic [21:0]        r_b_xk;
    logic signed [12:0] r_b_dt;
    logic [30:0]        r_b_prod;

    always_ff @(posedge i_clk) begin
        r_b_temp <= w_temp;
        r_b_raw  <= r_a_raw;
        r_b_a    <= w_aref[10:0];
        r_b_dba  <= w_dba;
        r_b_rv   <= w_rv;
        r_b_hv   <= w_hv;
        r_b_xk   <= w_xk;
        r_b_dt   <= w_dt;
        r_b_prod <= w_prod;
    end

    // stage C: voltage span, offset of the coarse reading, span checks
    logic               r_c_temp, r_c_err;
    logic [11:0]        r_c_raw;
    logic [10:0]        r_c_a;
    logic signed [8:0]  r_c_dba;
    logic [22:0]        r_c_rv;
    logic signed [23:0] r_c_dv, r_c_e;
    logic signed [12:0] r_c_dt;
    logic [30:0]        r_c_prod;

    always_ff @(posedge i_clk) begin
        r_c_temp <= r_b_temp;
        r_c_err  <= (r_b_hv == r_b_rv) || (r_b_dt == 13'sd0);
        r_c_raw  <= r_b_raw;
        r_c_a    <= r_b_a;
        r_c_dba  <= r_b_dba;
        r_c_rv   <= r_b_rv;
        r_c_dv   <= $signed({1'b0, r_b_hv}) - $signed({1'b0, r_b_rv});
        r_c_e    <= $signed({2'b00, r_b_xk}) - $signed({1'b0, r_b_rv});
        r_c_dt   <= r_b_dt;
        r_c_prod <= r_b_prod;
    end

    // stage D: products of the span
    logic signed [35:0] w_ad;
    logic signed [32:0] w_be;
    logic signed [47:0] w_sq;
    logic signed [46:0] w_rvdv;

    assign w_ad   = 36'($signed({1'b0, r_c_a})) * 36'(r_c_dv);
    assign w_be   = 33'(r_c_dba) * 33'(r_c_e);
    assign w_sq   = 48'(r_c_dv) * 48'(r_c_dv);
    assign w_rvdv = 47'($signed({1'b0, r_c_rv})) * 47'(r_c_dv);

    logic               r_d_temp, r_d_err;
    logic [11:0]        r_d_raw;
    logic signed [12:0] r_d_dt;
    logic [30:0]        r_d_prod;
    logic signed [35:0] r_d_ad;
    logic signed [32:0] r_d_be;
    logic [45:0]        r_d_dv2;
    logic signed [46:0] r_d_rvdv;

    always_ff @(posedge i_clk) begin
        r_d_temp <= r_c_temp;
        r_d_err  <= r_c_err;
        r_d_raw  <= r_c_raw;
        r_d_dt   <= r_c_dt;
        r_d_prod <= r_c_prod;
        r_d_ad   <= w_ad;
        r_d_be   <= w_be;
        r_d_dv2  <= w_sq[45:0];
        r_d_rvdv <= w_rvdv;
    end

    // stage E: corrected reference term, denominator, room term
    logic               r_e_temp, r_e_err;
    logic [11:0]        r_e_raw;
    logic signed [12:0] r_e_dt;
    logic [30:0]        r_e_prod;
    logic signed [35:0] r_e_n;
    logic [49:0]        r_e_den;
    logic [57:0]        r_e_tdv;
    logic signed [46:0] r_e_rvdv;

    always_ff @(posedge i_clk) begin
        r_e_temp <= r_d_temp;
        r_e_err  <= r_d_err;
        r_e_raw  <= r_d_raw;
        r_e_dt   <= r_d_dt;
        r_e_prod <= r_d_prod;
        r_e_n    <= r_d_ad + 36'(r_d_be);
        r_e_den  <= (50'(r_d_dv2) << 3) + (50'(r_d_dv2) << 1);
        r_e_tdv  <= 58'(i_cfg.room_temp_tenths) * 58'(r_d_dv2);
        r_e_rvdv <= r_d_rvdv;
    end

    // stage F: reading times corrected term
    logic               r_f_temp, r_f_err;
    logic signed [12:0] r_f_dt;
    logic [30:0]        r_f_prod;
    logic [49:0]        r_f_den;
    logic [57:0]        r_f_tdv;
    logic signed [46:0] r_f_rvdv;
    logic signed [47:0] r_f_xn;

    always_ff @(posedge i_clk) begin
        r_f_temp <= r_e_temp;
        r_f_err  <= r_e_err;
        r_f_dt   <= r_e_dt;
        r_f_prod <= r_e_prod;
        r_f_den  <= r_e_den;
        r_f_tdv  <= r_e_tdv;
        r_f_rvdv <= r_e_rvdv;
        r_f_xn   <= 48'($signed({1'b0, r_e_raw})) * 48'(r_e_n);
    end

    // stage G
    logic               r_g_temp, r_g_err;
    logic signed [12:0] r_g_dt;
    logic [30:0]        r_g_prod;
    logic [49:0]        r_g_den;
    logic [57:0]        r_g_tdv;
    logic signed [48:0] r_g_m;

    always_ff @(posedge i_clk) begin
        r_g_temp <= r_f_temp;
        r_g_err  <= r_f_err;
        r_g_dt   <= r_f_dt;
        r_g_prod <= r_f_prod;
        r_g_den  <= r_f_den;
        r_g_tdv  <= r_f_tdv;
        r_g_m    <= 49'(r_f_xn) - 49'(r_f_rvdv);
    end

    // stage H: temperature span weight
    logic               r_h_temp, r_h_err;
    logic [30:0]        r_h_prod;
    logic [49:0]        r_h_den;
    logic [57:0]        r_h_tdv;
    logic signed [61:0] r_h_dm;

    always_ff @(posedge i_clk) begin
        r_h_temp <= r_g_temp;
        r_h_err  <= r_g_err;
        r_h_prod <= r_g_prod;
        r_h_den  <= r_g_den;
        r_h_tdv  <= r_g_tdv;
        r_h_dm   <= 62'(r_g_dt) * 62'(r_g_m);
    end

    // stage I: numerator
    logic               r_i_temp, r_i_err;
    logic [30:0]        r_i_prod;
    logic [49:0]        r_i_den;
    logic signed [62:0] r_i_num;

    always_ff @(posedge i_clk) begin
        r_i_temp <= r_h_temp;
        r_i_err  <= r_h_err;
        r_i_prod <= r_h_prod;
        r_i_den  <= r_h_den;
        r_i_num  <= $signed({5'b00000, r_h_tdv}) + 63'(r_h_dm);
    end

    // stage J: pack the job; half the divisor added for round to nearest
    logic [62:0]     w_mag;
    adcrv_pkg::t_job w_job;
    adcrv_pkg::t_job r_j_job;

    assign w_mag = r_i_num[62] ? 63'(-r_i_num) : 63'(r_i_num);

    always_comb begin
        w_job         = '0;
        w_job.is_temp = r_i_temp;
        w_job.err     = r_i_temp & r_i_err;
        if (r_i_temp && r_i_err) begin
            w_job.divisor = 50'd1;
        end else if (r_i_temp) begin
            w_job.dividend = 80'({w_mag, 16'h0000}) + 80'(r_i_den[49:1]);
            w_job.divisor  = r_i_den;
            w_job.neg      = r_i_num[62];
        end else begin
            w_job.dividend = 80'({r_i_prod, 16'h0000}) + 80'(VOLT_DEN[49:1]);
            w_job.divisor  = VOLT_DEN;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j_job <= w_job;
    end

    assign o_job_valid = r_vld[9];
    assign o_job       = r_j_job;

endmodule

### design/adcrv_queue.sv
// Short job queue between front end and divider.
module adcrv_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  adcrv_pkg::t_job    i_job,
    output logic               o_job_valid,
    output adcrv_pkg::t_job    o_job,
    output adcrv_pkg::t_q_stat o_stat
);

    adcrv_pkg::t_job r_mem [adcrv_pkg::QUEUE_DEPTH];
    logic [adcrv_pkg::QPTR_W-1:0] r_wr, r_rd;
    logic [adcrv_pkg::QPTR_W:0]   r_cnt;
    logic w_pop, w_push;

    // divider takes a job every cycle that the queue is not empty
    assign w_pop  = (r_cnt != '0);
    assign w_push = i_push && (r_cnt != (adcrv_pkg::QPTR_W + 1)'(adcrv_pkg::QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (adcrv_pkg::QPTR_W + 1)'(w_push)
                           - (adcrv_pkg::QPTR_W + 1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_job;
    end

    assign o_job_valid     = w_pop;
    assign o_job           = r_mem[r_rd];
    assign o_stat.nonempty = w_pop;
    assign o_stat.full     = (r_cnt == (adcrv_pkg::QPTR_W + 1)'(adcrv_pkg::QUEUE_DEPTH));

endmodule

### design/adcrv_back.sv
// Back end: pipelined restoring divider, one quotient bit per stage, then saturation.
module adcrv_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_job_valid,
    input  adcrv_pkg::t_job      i_job,
    output logic                 o_res_valid,
    output adcrv_pkg::t_out_item o_result
);

    localparam int QW = adcrv_pkg::QUOT_W;
    localparam int DW = adcrv_pkg::DIVISOR_W;
    localparam int NW = adcrv_pkg::DIVIDEND_W;

    logic [QW:0]   r_v;
    logic [DW-1:0] r_rem [QW+1];
    logic [QW-1:0] r_lo  [QW+1];
    logic [QW-1:0] r_q   [QW+1];
    logic [DW-1:0] r_den [QW+1];
    logic [QW:0]   r_neg, r_temp, r_err, r_ovf;

    // entry: top part of the dividend is the first partial remainder
    logic [DW-1:0] w_top;
    assign w_top = DW'(i_job.dividend[NW-1:QW]);

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= w_top;
        r_lo[0]   <= i_job.dividend[QW-1:0];
        r_q[0]    <= '0;
        r_den[0]  <= i_job.divisor;
        r_neg[0]  <= i_job.neg;
        r_temp[0] <= i_job.is_temp;
        r_err[0]  <= i_job.err;
        r_ovf[0]  <= (w_top >= i_job.divisor);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[QW-1:0], i_job_valid};
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [DW:0] w_t;
        logic        w_ge;
        assign w_t  = {r_rem[k], r_lo[k][QW-1]};
        assign w_ge = (w_t >= {1'b0, r_den[k]});
        always_ff @(posedge i_clk) begin
            r_rem[k+1]  <= w_ge ? DW'(w_t - {1'b0, r_den[k]}) : w_t[DW-1:0];
            r_lo[k+1]   <= {r_lo[k][QW-2:0], 1'b0};
            r_q[k+1]    <= {r_q[k][QW-2:0], w_ge};
            r_den[k+1]  <= r_den[k];
            r_neg[k+1]  <= r_neg[k];
            r_temp[k+1] <= r_temp[k];
            r_err[k+1]  <= r_err[k];
            r_ovf[k+1]  <= r_ovf[k];
        end
    end

    // saturate to Q16.16, apply sign
    logic [QW-1:0]        w_q;
    logic signed [31:0]   w_val;
    adcrv_pkg::t_out_item r_out;
    logic                 r_out_v;

    assign w_q = r_q[QW];

    always_comb begin
        if (r_err[QW]) begin
            w_val = '0;
        end else if (r_neg[QW]) begin
            if (r_ovf[QW] || w_q[32] || (w_q[31] && (w_q[30:0] != '0))) begin
                w_val = 32'sh8000_0000;
            end else begin
                w_val = $signed(-w_q[31:0]);
            end
        end else begin
            if (r_ovf[QW] || w_q[32] || w_q[31]) begin
                w_val = 32'sh7FFF_FFFF;
            end else begin
                w_val = $signed(w_q[31:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_v[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.value          <= w_val;
        r_out.is_temperature <= r_temp[QW];
        r_out.calib_error    <= r_err[QW];
    end

    assign o_res_valid = r_out_v;
    assign o_result    = r_out;

endmodule

### tb/adc_result_to_volts_or_temperature_test.sv
// Testbench for the converter result scaling block: directed and random items against a predictor.
`timescale 1ns / 1ps

module adc_result_to_volts_or_temperature_test;
    import adcrv_pkg::*;

    // Expected results in arrival order, checked field by field.
    class scaled_value_board;
        t_out_item pending[$];
        int        errors;

        function void note_item(t_out_item exp_res);
            pending.push_back(exp_res);
        endfunction

        function void check_result(t_out_item got);
            t_out_item exp_res;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result value=%0d temp=%0b err=%0b", $time,
                         got.value, got.is_temperature, got.calib_error);
                errors++;
                return;
            end
            exp_res = pending.pop_front();
            if (got.value !== exp_res.value) begin
                $display("%0t: value expected %0d actual %0d", $time, exp_res.value,
                         got.value);
                errors++;
            end
            if (got.is_temperature !== exp_res.is_temperature) begin
                $display("%0t: is_temperature expected %0b actual %0b", $time,
                         exp_res.is_temperature, got.is_temperature);
                errors++;
            end
            if (got.calib_error !== exp_res.calib_error) begin
                $display("%0t: calib_error expected %0b actual %0b", $time,
                         exp_res.calib_error, got.calib_error);
                errors++;
            end
        endfunction
    endclass

    localparam longint Q_HI = 64'sd2147483647;
    localparam longint Q_LO = -64'sd2147483648;
    localparam int LATENCY = 46;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_in_item   i_item;
    logic       o_res_valid;
    t_out_item  o_result;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [2:0] i_cfg_index;
    logic [18:0] i_cfg_data;

    scaled_value_board board;
    t_cfg cal;   // predictor's copy of the registers

    adc_result_to_volts_or_temperature uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_item(i_item),
        .o_res_valid(o_res_valid), .o_result(o_result), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic longint clamp_q(longint v);
        if (v > Q_HI) return Q_HI;
        if (v < Q_LO) return Q_LO;
        return v;
    endfunction

    // round(65536*num/den), ties away from zero, saturated; den > 0
    function automatic longint round_q16(longint num, longint den);
        bit              neg;
        longint unsigned mag;
        longint unsigned q;
        longint unsigned r;
        longint          v;
        neg = num < 0;
        mag = neg ? -num : num;
        q = mag / den;
        r = mag % den;
        if (q > 32768) return neg ? Q_LO : Q_HI;
        v = q * 65536 + (r * 65536 + den / 2) / den;
        return clamp_q(neg ? -v : v);
    endfunction

    function automatic t_out_item predict_reading(t_in_item it);
        t_out_item       res;
        longint          a, b, rv, hv, dv, tr, dt, x, n, num;
        longint unsigned s;
        res = '0;
        if (it.channel == CH_TEMP) begin
            // two-point calibration with reference drift correction
            a = 1000 - longint'(cal.room_ref_drift);
            b = 1000 - longint'(cal.hot_ref_drift);
            rv = a * cal.room_code;
            hv = b * cal.hot_code;
            dv = hv - rv;
            tr = cal.room_temp_tenths;
            dt = longint'(cal.hot_temp_tenths) - tr;
            x = it.raw_code;
            res.is_temperature = 1'b1;
            if (dv == 0 || dt == 0) begin
                res.calib_error = 1'b1;
            end else begin
                n = a * dv + (b - a) * (x * 1000 - rv);
                num = tr * dv * dv + dt * (x * n - rv * dv);
                res.value = 32'(round_q16(num, 10 * dv * dv));
            end
        end else begin
            if (it.channel == CH_BANDGAP) s = 2 * cal.internal_ref_volts;
            else if (it.channel == CH_SUPPLY_A || it.channel == CH_SUPPLY_B)
                s = 4 * cal.internal_ref_volts;
            else s = cal.pin_full_scale_volts;
            res.value = 32'(clamp_q((s * it.raw_code + 2047) / 4095));
        end
        return res;
    endfunction

    // One write; valid drops before the next write.
    task automatic write_reg(logic [2:0] idx, logic [18:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_ROOM_TEMP:  cal.room_temp_tenths = data[11:0];
            CFG_HOT_TEMP:   cal.hot_temp_tenths = data[11:0];
            CFG_ROOM_CODE:  cal.room_code = data[11:0];
            CFG_HOT_CODE:   cal.hot_code = data[11:0];
            CFG_ROOM_DRIFT: cal.room_ref_drift = data[7:0];
            CFG_HOT_DRIFT:  cal.hot_ref_drift = data[7:0];
            CFG_IREF:       cal.internal_ref_volts = data[16:0];
            default:        cal.pin_full_scale_volts = data[18:0];
        endcase
    endtask

    // Random gap, then one item held until accepted; start stays high into
    // the next item when it has no gap.
    task automatic send_item(logic [4:0] ch, logic [11:0] code);
        t_in_item it;
        int gap;
        it.channel = ch;
        it.raw_code = code;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        if ($urandom_range(0, 1) == 0) gap = 0;   // long back-to-back stretches
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.note_item(predict_reading(it));
    endtask

    // Wait out every in-flight item before touching registers.
    task automatic drain;
        int guard;
        guard = 0;
        start <= 1'b0;
        while (board.pending.size() != 0 && guard < 10000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_calibration(logic [11:0] rt, logic [11:0] ht, logic [11:0] rc,
                                    logic [11:0] hc, logic [7:0] rd, logic [7:0] hd,
                                    logic [16:0] iref, logic [18:0] pfs);
        write_reg(CFG_ROOM_TEMP, 19'(rt));
        write_reg(CFG_HOT_TEMP, 19'(ht));
        write_reg(CFG_ROOM_CODE, 19'(rc));
        write_reg(CFG_HOT_CODE, 19'(hc));
        write_reg(CFG_ROOM_DRIFT, 19'(rd));
        write_reg(CFG_HOT_DRIFT, 19'(hd));
        write_reg(CFG_IREF, 19'(iref));
        write_reg(CFG_PIN_FS, pfs);
    endtask

    function automatic logic [4:0] pick_channel();
        case ($urandom_range(0, 5))
            0, 1:    return CH_TEMP;
            2:       return CH_BANDGAP;
            3:       return $urandom_range(0, 1) ? CH_SUPPLY_A : CH_SUPPLY_B;
            default: return 5'($urandom_range(0, 31));
        endcase
    endfunction

    function automatic logic [11:0] pick_code();
        case ($urandom_range(0, 7))
            0:       return 12'd0;
            1:       return 12'hFFF;
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    // Result side: sampled at the edge that ends the strobe cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid) board.check_result(o_result);
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        logic [4:0] chans[8];
        board = new();
        start = 1'b0;
        i_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        cal = '0;
        cal.internal_ref_volts = 17'd65536;
        cal.pin_full_scale_volts = 19'd65536;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset defaults: temperature spans are zero, so calib_error.
        chans = '{CH_TEMP, CH_BANDGAP, CH_SUPPLY_A, CH_SUPPLY_B, 5'd0, 5'd23, 5'd28, 5'd31};
        foreach (chans[i]) send_item(chans[i], 12'hFFF);
        send_item(CH_TEMP, 12'd0);
        drain();

        // Extremes: full-scale registers to saturate, drifts at both ends.
        load_calibration(12'd250, 12'd2565, 12'd1500, 12'd4095, 8'h80, 8'h7F,
                         17'h1FFFF, 19'h7FFFF);
        foreach (chans[i]) send_item(chans[i], 12'hFFF);
        send_item(CH_TEMP, 12'd0);
        send_item(5'd5, 12'd0);
        drain();

        // Zero voltage span with nonzero temperature span, then tiny span -> saturation.
        load_calibration(12'd0, 12'd2565, 12'd2000, 12'd2000, 8'd0, 8'd0, 17'd0, 19'd0);
        send_item(CH_TEMP, 12'd1234);
        send_item(CH_BANDGAP, 12'hFFF);
        send_item(5'd3, 12'hFFF);
        drain();
        write_reg(CFG_HOT_CODE, 19'd2001);
        send_item(CH_TEMP, 12'hFFF);
        send_item(CH_TEMP, 12'd0);
        drain();

        // Random phases with random calibration each time.
        for (int ph = 0; ph < 13; ph++) begin
            if (ph % 4 == 3)
                load_calibration(12'($urandom_range(0, 2565)), 12'($urandom_range(0, 2565)),
                                 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                                 8'($urandom), 8'($urandom), 17'($urandom_range(0, 131071)),
                                 19'($urandom_range(0, 524287)));
            else
                load_calibration(12'($urandom_range(200, 300)),
                                 12'($urandom_range(800, 1300)),
                                 12'($urandom_range(1000, 2000)),
                                 12'($urandom_range(2200, 3500)),
                                 8'($urandom_range(0, 20)), 8'($urandom_range(0, 20)),
                                 17'($urandom_range(60000, 70000)),
                                 19'($urandom_range(0, 524287)));
            repeat (100) send_item(pick_channel(), pick_code());
            drain();
        end

        repeat (LATENCY + 10) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

### adc_result_to_volts_or_temperature.f
+incdir+design
design/adcrv_pkg.sv
design/adcrv_front.sv
design/adcrv_queue.sv
design/adcrv_back.sv
design/adc_result_to_volts_or_temperature.sv
tb/adc_result_to_volts_or_temperature_test.sv
